@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/ptw_pkg.sv @@
// Shared types and constants of the page-table walker.
package ptw_pkg;
  localparam int unsigned EntryW = 64;
  localparam int unsigned IdxW = 9;
  localparam int unsigned PaW = 60;
  localparam int unsigned BaseShift = 12;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncXlate = 1'b1;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegLoRoot = 3'd1;
  localparam logic [2:0] RegUpRoot = 3'd2;
  localparam logic [2:0] RegVaBits = 3'd3;
  localparam logic [2:0] RegPaBits = 3'd4;

  localparam int unsigned BitV = 0;
  localparam int unsigned BitHuge = 6;
  localparam int unsigned BitG = 6;
  localparam int unsigned BitP = 7;
  localparam int unsigned BitW = 8;
  localparam int unsigned BitHg = 12;
  localparam int unsigned BitNr = 61;
  localparam int unsigned BitNx = 62;

  // Classified item handed from the front end to the walker.
  typedef struct packed {
    logic        is_write;
    logic        wr_ok;     // write lands inside the store
    logic        pre_ok;    // translate passed enable/canonical/root checks
    logic [63:0] addr;
    logic [63:0] data;
    logic [59:0] root;      // masked root table address
    logic [59:0] pmask;     // entry address mask
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [59:0] phys_addr;
    logic [5:0]  page_shift;
    logic        readable;
    logic        writable;
    logic        executable;
    logic        global_page;
    logic        user_page;
    logic        device_memory;
  } res_t;
endpackage

@@ rtl/ptw_ram.sv @@
// Generic single-port RAM with registered read.
module ptw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/ptw_front.sv @@
// Front end: configuration registers, item classification, command queue.
module ptw_front import ptw_pkg::*; #(
  parameter int unsigned TablePages = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] address_i,
  input  logic [63:0] write_data_i,
  output logic        cmd_valid_o,
  input  logic        cmd_pop_i,
  output cmd_t        cmd_o
);
  logic        en_q;
  logic [59:0] lo_root_q, up_root_q;
  logic [5:0]  va_bits_q, pa_bits_q;
  logic [5:0]  vb, pb;
  logic        sign;
  logic [63:0] canon_lo, canon_hi;
  logic        canon;
  logic [59:0] pmask, root;
  cmd_t        cmd;
  // two-entry queue
  cmd_t        q_mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      lo_root_q <= '0;
      up_root_q <= '0;
      va_bits_q <= 6'd48;
      pa_bits_q <= 6'd48;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegEnable: en_q <= cfg_data_i[0];
        RegLoRoot: lo_root_q <= cfg_data_i[59:0];
        RegUpRoot: up_root_q <= cfg_data_i[59:0];
        RegVaBits: va_bits_q <= cfg_data_i[5:0];
        RegPaBits: pa_bits_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    vb = (va_bits_q < 6'd40) ? 6'd40 : (va_bits_q > 6'd48) ? 6'd48 : va_bits_q;
    pb = (pa_bits_q < 6'd40) ? 6'd40 : (pa_bits_q > 6'd60) ? 6'd60 : pa_bits_q;
    sign = address_i[vb - 6'd1];
    // bits at and above vb-1 must all equal the sign
    canon_lo = {64{1'b1}} << (vb - 6'd1);
    canon_hi = address_i & canon_lo;
    canon = sign ? (canon_hi == canon_lo) : (canon_hi == '0);
    pmask = (({60{1'b1}} >> (7'd60 - {1'b0, pb}))) & ~60'hfff;
    root = (sign ? up_root_q : lo_root_q) & pmask;
    cmd.is_write = (func_i == FuncWrite);
    cmd.wr_ok = (address_i[63:12] < 52'(TablePages));
    cmd.pre_ok = en_q && canon && (root != '0);
    cmd.addr = address_i;
    cmd.data = write_data_i;
    cmd.root = root;
    cmd.pmask = pmask;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

@@ rtl/ptw_walk.sv @@
// Back end: table store, clearing pass, walk sequencer, result register.
module ptw_walk import ptw_pkg::*; #(
  parameter int unsigned TablePages = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_pop_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        res_o,
  output logic        busy_o
);
  localparam int unsigned Depth = TablePages * 512;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned PgW = $clog2(TablePages);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StEval  = 3'd3;

  logic [2:0]    st_q, st_d;
  logic [AW-1:0] clr_q;
  logic [1:0]    lvl_q;
  logic [59:0]   tbl_q;
  cmd_t          cur_q;
  res_t          res_q;
  logic          ov_q;
  logic          we;
  logic [AW-1:0] ra;
  logic [63:0]   wd, rd;
  logic [59:0]   pg;
  logic [8:0]    idx;
  logic          leaf, pv;
  logic [5:0]    sh;
  logic [59:0]   lmask;
  res_t          rnew;
  res_t          rfirst;

  ptw_ram #(.Width(EntryW), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ra), .wdata_i(wd), .rdata_o(rd)
  );

  assign pg = tbl_q >> BaseShift;
  assign idx = cur_q.addr[BaseShift + 9*lvl_q +: 9];
  assign sh = 6'(BaseShift + 9*lvl_q);
  assign leaf = (lvl_q == 2'd0) || rd[BitHuge];
  assign pv = rd[BitP] && rd[BitV];
  assign lmask = ~({60{1'b1}} << sh);
  assign cmd_pop_o = (st_q == StIdle) && cmd_valid_i && !ov_q;

  always_comb begin
    we = 1'b0;
    wd = cmd_i.data;
    ra = {pg[PgW-1:0], idx};
    if (st_q == StClear) begin
      we = 1'b1;
      wd = '0;
      ra = clr_q;
    end else if (cmd_pop_o && cmd_i.is_write) begin
      we = cmd_i.wr_ok;
      ra = {cmd_i.addr[BaseShift +: PgW], cmd_i.addr[11:3]};
    end
  end

  always_comb begin
    rnew = '0;
    rnew.ok = 1'b1;
    rnew.phys_addr = ((rd[59:0] & cur_q.pmask) & ~lmask) | (cur_q.addr[59:0] & lmask);
    rnew.page_shift = sh;
    rnew.readable = !rd[BitNr];
    rnew.writable = rd[BitW];
    rnew.executable = !rd[BitNx];
    rnew.global_page = (lvl_q == 2'd0) ? rd[BitG] : rd[BitHg];
    rnew.user_page = (rd[3:2] == 2'b11);
    rnew.device_memory = (rd[5:4] != 2'b01);
  end

  // result taken at pop: write status, or a cleared beat for a walk
  always_comb begin
    rfirst = '0;
    rfirst.ok = cmd_i.is_write && cmd_i.wr_ok;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClear: if (clr_q == AW'(Depth - 1)) st_d = StIdle;
      StIdle:  if (cmd_pop_o) st_d = cmd_i.is_write ? StIdle :
                                      (cmd_i.pre_ok ? StRead : StIdle);
      StRead:  st_d = (pg < 60'(TablePages)) ? StEval : StIdle;
      StEval:  st_d = (rd == '0 || leaf) ? StIdle : StRead;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + AW'(1);
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      else if (cmd_pop_o && (cmd_i.is_write || !cmd_i.pre_ok)) ov_q <= 1'b1;
      else if (st_q == StRead && !(pg < 60'(TablePages))) ov_q <= 1'b1;
      else if (st_q == StEval && (rd == '0 || leaf)) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
      tbl_q <= cmd_i.root;
      lvl_q <= 2'd3;
      res_q <= rfirst;
    end else if (st_q == StRead && !(pg < 60'(TablePages))) begin
      res_q <= '0;
    end else if (st_q == StEval) begin
      if (rd == '0 || (leaf && !pv)) res_q <= '0;
      else if (leaf) res_q <= rnew;
      else begin
        tbl_q <= rd[59:0] & cur_q.pmask;
        lvl_q <= lvl_q - 2'd1;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign res_o = res_q;
  assign busy_o = (st_q != StIdle);
endmodule

@@ rtl/page_table_walk_translate_core.sv @@
// Top level of the four-level page-table walker.
// Usage:
// - Config port (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): one register
//   per beat, index 0..4 as enable, lower root, upper root, va bits, pa bits.
// - Input channel (in_valid_i/in_stall_o): func 0 writes an entry at address,
//   func 1 translates the virtual address.
// - Output channel (out_valid_o/out_stall_i): one result beat per item.
// - Front end classifies items (canonical check, root select) into a two-beat
//   queue; the back end walks the table store, one synchronous RAM port.
// - A write or early failure sets the result register at the pop; a translate
//   runs a read state and an evaluate state per level, for up to four levels.
// - The walker pops no new item until the last result has been accepted.
// - After reset the store's TABLE_PAGES*512 entries are cleared one entry per
//   cycle, while items wait in the queue; config writes are taken at once.
// - A stalled output holds the result; the walker then waits before the next
//   item, and the queue keeps taking input until it is full.
module page_table_walk_translate_core import ptw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] address_i,
  input  logic [63:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [59:0] phys_addr_o,
  output logic [5:0]  page_shift_o,
  output logic        readable_o,
  output logic        writable_o,
  output logic        executable_o,
  output logic        global_page_o,
  output logic        user_page_o,
  output logic        device_memory_o
);
`include "assert_macros.svh"
  logic cmd_valid, cmd_pop, busy;
  cmd_t cmd;
  res_t res;

  ptw_front #(.TablePages(TABLE_PAGES)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .address_i, .write_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  ptw_walk #(.TablePages(TABLE_PAGES)) u_walk (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .res_o(res), .busy_o(busy)
  );

  assign ok_o = res.ok;
  assign phys_addr_o = res.phys_addr;
  assign page_shift_o = res.page_shift;
  assign readable_o = res.readable;
  assign writable_o = res.writable;
  assign executable_o = res.executable;
  assign global_page_o = res.global_page;
  assign user_page_o = res.user_page;
  assign device_memory_o = res.device_memory;

  `ASSERT_IMPL(a_pop_needs_valid, clk_i, rst_ni, cmd_pop, cmd_valid && !out_valid_o && !busy)
  `ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_o && !ok_o, phys_addr_o == '0)
  `ASSERT_NEXT(a_pop_busy, clk_i, rst_ni, cmd_pop && cmd.is_write, !cmd_pop)
endmodule

@@ tb/tb_page_table_walk_translate_core.sv @@
// Testbench for the page-table walker: predicts each result and checks beats in order.
`timescale 1ns / 100ps

module tb_page_table_walk_translate_core;
  import ptw_pkg::*;

  localparam int unsigned TablePages = 64;
  // no-accept limit; covers the store clearing pass after reset with margin
  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned PhaseItems = 88;

  // Predictor and result queue. Holds its own copy of the store and registers.
  class xlate_scoreboard;
    logic [63:0] store_mem [int];
    logic        walk_en;
    logic [59:0] lo_root, up_root;
    logic [5:0]  va_bits, pa_bits;
    res_t        expected_q[$];
    int unsigned errors;
    int unsigned shift_hits [4];

    function new();
      walk_en = 1'b0;
      lo_root = '0;
      up_root = '0;
      va_bits = 6'd48;
      pa_bits = 6'd48;
      errors  = 0;
      foreach (shift_hits[i]) shift_hits[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        RegEnable: walk_en = d[0];
        RegLoRoot: lo_root = d[59:0];
        RegUpRoot: up_root = d[59:0];
        RegVaBits: va_bits = d[5:0];
        RegPaBits: pa_bits = d[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_va();
      if (va_bits < 40) return 40;
      if (va_bits > 48) return 48;
      return 32'(va_bits);
    endfunction

    function logic [63:0] addr_mask();
      int unsigned pa;
      pa = 32'(pa_bits);
      if (pa < 40) pa = 40;
      if (pa > 60) pa = 60;
      return ((64'h1 << pa) - 64'h1) & ~64'hfff;
    endfunction

    function logic [63:0] read_entry(logic [63:0] tbl, logic [63:0] idx);
      logic [63:0] pg;
      int key;
      pg = tbl >> BaseShift;
      if (pg >= TablePages) return '0;
      key = int'(pg) * 512 + int'(idx[8:0]);
      return store_mem.exists(key) ? store_mem[key] : 64'h0;
    endfunction

    function res_t translate(logic [63:0] va);
      res_t r;
      int unsigned vb, sh;
      logic [63:0] pm, tbl, e, lm, hi_want;
      logic sgn;
      r = '0;
      vb = eff_va();
      pm = addr_mask();
      sgn = va[vb-1];
      hi_want = sgn ? ((64'h1 << (64 - vb)) - 64'h1) : 64'h0;
      tbl = (sgn ? {4'h0, up_root} : {4'h0, lo_root}) & pm;
      if (!walk_en || tbl == 0 || (va >> vb) != hi_want) return r;
      for (int lv = 3; lv >= 0; lv--) begin
        sh = BaseShift + 9 * lv;
        e = read_entry(tbl, (va >> sh) & 64'h1ff);
        if (e == 0) return r;
        if (lv == 0 || e[BitHuge]) begin
          if (!(e[BitP] && e[BitV])) return r;
          lm = (64'h1 << sh) - 64'h1;
          r.ok            = 1'b1;
          r.phys_addr     = 60'(((e & pm) & ~lm) | (va & lm));
          r.page_shift    = 6'(sh);
          r.readable      = !e[BitNr];
          r.writable      = e[BitW];
          r.executable    = !e[BitNx];
          r.global_page   = (sh == BaseShift) ? e[BitG] : e[BitHg];
          r.user_page     = (e[3:2] == 2'b11);
          r.device_memory = (e[5:4] != 2'b01);
          return r;
        end
        tbl = e & pm;
      end
      return r;
    endfunction

    // Accepted input beat: update the store or walk it, queue the expected result.
    function void note_item(logic func, logic [63:0] addr, logic [63:0] data);
      res_t r;
      logic [63:0] pg;
      r = '0;
      if (func == FuncWrite) begin
        pg = addr >> BaseShift;
        if (pg < TablePages) begin
          store_mem[int'(pg) * 512 + int'(addr[11:3])] = data;
          r.ok = 1'b1;
        end
      end else begin
        r = translate(addr);
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t act);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("ok", 64'(e.ok), 64'(act.ok));
      check_field("phys_addr", 64'(e.phys_addr), 64'(act.phys_addr));
      check_field("page_shift", 64'(e.page_shift), 64'(act.page_shift));
      check_field("readable", 64'(e.readable), 64'(act.readable));
      check_field("writable", 64'(e.writable), 64'(act.writable));
      check_field("executable", 64'(e.executable), 64'(act.executable));
      check_field("global_page", 64'(e.global_page), 64'(act.global_page));
      check_field("user_page", 64'(e.user_page), 64'(act.user_page));
      check_field("device_memory", 64'(e.device_memory), 64'(act.device_memory));
      if (e.ok && e.page_shift != 0) shift_hits[(e.page_shift - BaseShift) / 9]++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [63:0] address_i = '0;
  logic [63:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [59:0] phys_addr_o;
  logic [5:0]  page_shift_o;
  logic        readable_o, writable_o, executable_o;
  logic        global_page_o, user_page_o, device_memory_o;

  page_table_walk_translate_core #(.TABLE_PAGES(TablePages)) u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  xlate_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_items = 0;
  int unsigned quiet_cycles = 0;

  // Result side: check accepted beats, then pick the next cycle's stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{ok_o, phys_addr_o, page_shift_o, readable_o, writable_o,
                        executable_o, global_page_o, user_page_o, device_memory_o});
    end
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: ends the run after a long stretch with no beat on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat; idle cycles first at the phase rate, then hold until taken.
  task automatic send(logic func, logic [63:0] addr, logic [63:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(func, addr, data);
    n_items++;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
  endtask

  // Let every queued result come back before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Small index pool so walks keep landing on entries already written.
  function automatic logic [8:0] pool_idx();
    case ($urandom_range(3))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'h1ff;
      default: return 9'h0a5;
    endcase
  endfunction

  function automatic logic [63:0] pool_page();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 90) return 64'($urandom_range(1, 7));
    if (r < 95) return 64'd0;
    if (r < 98) return 64'(TablePages - 1);
    return 64'($urandom_range(TablePages, 4 * TablePages));
  endfunction

  function automatic logic [63:0] rand_va();
    logic [63:0] va;
    int unsigned vb;
    logic sgn;
    vb = sb.eff_va();
    va = {16'h0, pool_idx(), pool_idx(), pool_idx(), pool_idx(), 12'(rand64())};
    sgn = 1'($urandom_range(1));
    for (int b = vb - 1; b < 64; b++) va[b] = sgn;
    if ($urandom_range(9) == 0) va[$urandom_range(vb, 63)] ^= 1'b1;
    return va;
  endfunction

  function automatic logic [63:0] rand_entry();
    logic [63:0] d;
    int unsigned r;
    r = $urandom_range(99);
    d = rand64();
    if (r < 50) begin
      // table pointer: huge bit clear
      d = (pool_page() << 12) | (d & 64'hf000_0000_0000_0fbf);
    end else if (r < 80) begin
      d[BitP] = 1'b1;
      d[BitV] = 1'b1;
    end else if (r < 88) begin
      d[BitP] = 1'($urandom_range(1));
      d[BitV] = !d[BitP];
    end else if (r < 94) begin
      d = '0;
    end
    return d;
  endfunction

  task automatic rand_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40)
      send(FuncWrite, (pool_page() << 12) | {pool_idx(), 3'($urandom)}, rand_entry());
    else if (r < 90)
      send(FuncXlate, rand_va(), rand64());
    else
      send(1'($urandom_range(1)), rand64(), rand64());
  endtask

  task automatic set_regs(int p);
    logic [63:0] lo, up;
    logic [5:0] va_tab [8], pa_tab [8];
    va_tab = '{6'd48, 6'd40, 6'd44, 6'd63, 6'd0, 6'd47, 6'd41, 6'd48};
    pa_tab = '{6'd48, 6'd40, 6'd60, 6'd63, 6'd0, 6'd52, 6'd44, 6'd48};
    lo = (64'd1 << 12) | (rand64() & 64'hfff);
    up = (64'd2 << 12) | (rand64() & 64'hf000_0000_0000_0fff);
    if (p == 6) lo = '0;                        // zero root
    if (p == 7) lo = 64'h0800_0000_0000_0000;   // masked away by pa bits
    cfg_write(RegEnable, (rand64() & ~64'h1) | 64'(p != 5));
    cfg_write(RegLoRoot, lo);
    cfg_write(RegUpRoot, up);
    cfg_write(RegVaBits, (rand64() & ~64'h3f) | 64'(va_tab[p]));
    cfg_write(RegPaBits, (rand64() & ~64'h3f) | 64'(pa_tab[p]));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unused indexes must be ignored.
    cfg_write(3'd5, rand64());
    cfg_write(3'd6, rand64());
    cfg_write(3'd7, rand64());

    // Walker still disabled: translation fails.
    send(FuncXlate, 64'h0, 64'h0);
    // Writes outside the store.
    send(FuncWrite, '1, '1);
    send(FuncWrite, 64'(TablePages) << 12, 64'h1234);
    // Four-level chain: page1 -> 3 -> 4 -> 5, low address bits ignored.
    send(FuncWrite, (64'd1 << 12) | 64'h7, 64'd3 << 12);
    send(FuncWrite, 64'd3 << 12, 64'd4 << 12);
    send(FuncWrite, 64'd4 << 12, 64'd5 << 12);
    send(FuncWrite, 64'd5 << 12, 64'h6000_0abc_de00_01dd);
    send(FuncXlate, 64'h0abc, '0);
    drain();
    cfg_write(RegEnable, 64'h1);
    cfg_write(RegLoRoot, 64'd1 << 12);
    cfg_write(RegUpRoot, 64'd2 << 12);

    send(FuncXlate, 64'h0abc, '0);
    // Huge leaves at levels 1, 3 and 2.
    send(FuncWrite, (64'd4 << 12) | (64'd1 << 3), 64'h4000_0000_4000_10c1);
    send(FuncXlate, (64'd1 << 21) | 64'h12345, '0);
    send(FuncWrite, (64'd1 << 12) | (64'd5 << 3), 64'h0fff_ffff_ffff_f0cd);
    send(FuncXlate, (64'd5 << 39) | 64'h12_3456_789a, '0);
    send(FuncWrite, (64'd3 << 12) | (64'd2 << 3), 64'h2000_0000_8000_00f1);
    send(FuncXlate, (64'd2 << 30) | 64'h1234_5678, '0);
    // Leaf with P clear fails.
    send(FuncWrite, (64'd5 << 12) | (64'd3 << 3), 64'h0000_0000_0009_0001);
    send(FuncXlate, 64'd3 << 12, '0);
    // Non-canonical, then upper half with an empty and an out-of-store table.
    send(FuncXlate, 64'h0001_0000_0000_0000, '0);
    send(FuncXlate, 64'hffff_8000_0000_0000, '0);
    send(FuncWrite, (64'd2 << 12) | (64'd256 << 3), 64'd100 << 12);
    send(FuncXlate, 64'hffff_8000_0000_0000, '0);
    send(FuncXlate, '1, '0);

    // Random phases: new registers each, idling pattern rotating.
    for (int p = 0; p < 8; p++) begin
      drain();
      set_regs(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      repeat (PhaseItems) rand_item();
    end

    drain();
    $display("Run covered %0d items over 8 register settings and 4 idle patterns.", n_items);
    $display("Hits by page size 4K/2M/1G/512G: %0d/%0d/%0d/%0d", sb.shift_hits[0],
             sb.shift_hits[1], sb.shift_hits[2], sb.shift_hits[3]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
